@@ hw/rtl/psl_pkg.sv @@
// Shared types, codes and constants of the per-source token bucket limiter.
package psl_pkg;

    localparam int S_TDATA_W   = 136;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int FIELD_CNT_W = 17;

    localparam logic [1:0] ACT_CHECK = 2'd0;
    localparam logic [1:0] ACT_SWEEP = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic [1:0] VERDICT_ALLOW     = 2'd0;
    localparam logic [1:0] VERDICT_NO_TOKENS = 2'd1;
    localparam logic [1:0] VERDICT_FULL      = 2'd2;
    localparam logic [1:0] VERDICT_MAINT     = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_COST      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CEILING   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH  = 3'd5;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_LOOKUP,
        ST_ELAPSE,
        ST_REFILL,
        ST_UPDATE,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_SWEEP_FIN,
        ST_RESULT
    } psl_state_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_ROUND,
        HS_FOLD,
        HS_MOD
    } hash_state_t;

    typedef struct packed {
        logic start;
        logic ipv6;
    } hash_ctl_t;

endpackage

@@ hw/rtl/per_source_token_bucket_limiter.sv @@
// Check: SipHash, 12 half rounds for IPv6 or 10 for IPv4, then a serial modulo for a non power of two BUCKETS.
// Sweep and flush: every bucket row in turn, one bucket row read and written back per cycle.
// One request at a time; the next is taken while the previous result waits at m_.
// Reset is synchronous; afterwards a clearing pass writes every row of the table to zero
// and s_tready stays low until it ends. Configuration writes are always taken.
module per_source_token_bucket_limiter #(
    parameter int BUCKETS   = 8192,
    parameter int WAYS      = 8,
    parameter int TIME_BITS = 48
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // family, context_id, address_prefix, now, zero fill
    input  logic [psl_pkg::S_TDATA_W-1:0]      s_tdata,
    // action
    input  logic [psl_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // verdict, removed_count, live_count, zero fill
    output logic [psl_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [psl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import psl_pkg::*;

    localparam int BW      = $clog2(BUCKETS);
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS   = BUCKETS * WAYS;
    localparam int CNT_W   = ($clog2(SLOTS + 1) > FIELD_CNT_W) ? $clog2(SLOTS + 1) : FIELD_CNT_W;
    localparam int P_LSB   = 1;
    localparam int C_LSB   = 65;
    localparam int T_LSB   = 82;
    localparam int K_LSB   = T_LSB + TIME_BITS;
    localparam int ENTRY_W = K_LSB + 32;

    function automatic logic [63:0] swap64(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 8; i++) begin
            y[8*i +: 8] = x[56 - 8*i +: 8];
        end
        swap64 = y;
    endfunction

    logic [31:0] cost_reg, ceil_reg, timeout_reg;
    logic [16:0] limit_reg;
    logic [63:0] key_lo_reg, key_hi_reg;

    psl_state_t         state_reg, state_next;
    logic [1:0]         act_reg, act_next;
    logic               fam_reg, fam_next;
    logic [15:0]        ctx_reg, ctx_next;
    logic [63:0]        prefix_reg, prefix_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [BW-1:0]      bucket_reg, bucket_next;
    logic [BW-1:0]      row_reg, row_next;
    logic [BW-1:0]      sweep_addr_reg, sweep_addr_next;
    logic               pend_reg, pend_next;
    logic               hash_start_reg, hash_start_next;
    logic               hit_reg, hit_next;
    logic [WW-1:0]      hit_way_reg, hit_way_next;
    logic               free_reg, free_next;
    logic [WW-1:0]      free_way_reg, free_way_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [31:0]        tok_reg, tok_next;
    logic [TIME_BITS-1:0] diff_reg, diff_next;
    logic [32:0]        t_reg, t_next;
    logic [CNT_W-1:0]   removed_reg, removed_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [1:0]         verdict_reg, verdict_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    hash_ctl_t          hash_ctl;
    logic               hash_done;
    logic [BW-1:0]      hash_bucket;
    logic [63:0]        w0, w1, w2, pswap;

    logic                          rd_en, wr_en;
    logic [BW-1:0]                 rd_addr, wr_addr;
    logic [WAYS-1:0][ENTRY_W-1:0]  rd_data;
    logic [WAYS-1:0]               wr_lane;
    logic [ENTRY_W-1:0]            wr_data;

    logic                 s_fire;
    logic [63:0]          now64;
    logic [16:0]          tagctx;
    logic                 found_hit, found_free;
    logic [WW-1:0]        found_hit_way, found_free_way;
    logic [TIME_BITS-1:0] found_last;
    logic [31:0]          found_tok;
    logic [WAYS-1:0]      freed;
    logic [31:0]          cap;
    logic [31:0]          new_tok;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign now64     = {16'd0, s_tdata[128:81]};
    assign tagctx    = {fam_reg, ctx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg    <= 32'd50000;
            ceil_reg    <= 32'd250000;
            timeout_reg <= 32'd1000000;
            limit_reg   <= 17'd65536;
            key_lo_reg  <= '0;
            key_hi_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_COST:     cost_reg    <= cfg_data[31:0];
                REG_CEILING:  ceil_reg    <= cfg_data[31:0];
                REG_TIMEOUT:  timeout_reg <= cfg_data[31:0];
                REG_LIMIT:    limit_reg   <= cfg_data[16:0];
                REG_KEY_LOW:  key_lo_reg  <= cfg_data;
                REG_KEY_HIGH: key_hi_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pswap = swap64(prefix_reg);
    assign w0    = {48'd0, ctx_reg};
    assign w1    = fam_reg ? pswap : {8'd12, 24'd0, pswap[31:0]};
    assign w2    = {8'd16, 56'd0};

    assign hash_ctl.start = hash_start_reg;
    assign hash_ctl.ipv6  = fam_reg;

    psl_hash #(.BUCKETS(BUCKETS)) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (hash_ctl),
        .key_lo  (key_lo_reg),
        .key_hi  (key_hi_reg),
        .word0   (w0),
        .word1   (w1),
        .word2   (w2),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    psl_ram #(.DEPTH(BUCKETS), .LANES(WAYS), .LANE_W(ENTRY_W)) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_lane (wr_lane),
        .wr_data (wr_data)
    );

    always_comb begin
        found_hit      = 1'b0;
        found_free     = 1'b0;
        found_hit_way  = '0;
        found_free_way = '0;
        found_last     = '0;
        found_tok      = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (rd_data[w][0]) begin
                if (!found_hit && rd_data[w][C_LSB-1:P_LSB] == prefix_reg &&
                    rd_data[w][T_LSB-1:C_LSB] == tagctx) begin
                    found_hit     = 1'b1;
                    found_hit_way = WW'(w);
                    found_last    = rd_data[w][K_LSB-1:T_LSB];
                    found_tok     = rd_data[w][ENTRY_W-1:K_LSB];
                end
            end else if (!found_free) begin
                found_free     = 1'b1;
                found_free_way = WW'(w);
            end
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            freed[w] = rd_data[w][0] &&
                       (act_reg == ACT_FLUSH ||
                        (rd_data[w][K_LSB-1:T_LSB] <= now_reg &&
                         (now_reg - rd_data[w][K_LSB-1:T_LSB]) > TIME_BITS'(timeout_reg)));
        end
    end

    assign cap     = (t_reg > {1'b0, ceil_reg}) ? ceil_reg : t_reg[31:0];
    assign new_tok = (ceil_reg >= cost_reg) ? ceil_reg - cost_reg : 32'd0;

    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        fam_next        = fam_reg;
        ctx_next        = ctx_reg;
        prefix_next     = prefix_reg;
        now_next        = now_reg;
        bucket_next     = bucket_reg;
        row_next        = row_reg;
        sweep_addr_next = sweep_addr_reg;
        pend_next       = pend_reg;
        hash_start_next = 1'b0;
        hit_next        = hit_reg;
        hit_way_next    = hit_way_reg;
        free_next       = free_reg;
        free_way_next   = free_way_reg;
        last_next       = last_reg;
        tok_next        = tok_reg;
        diff_next       = diff_reg;
        t_next          = t_reg;
        removed_next    = removed_reg;
        live_next       = live_reg;
        verdict_next    = verdict_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        rd_en           = 1'b0;
        rd_addr         = row_reg;
        wr_en           = 1'b0;
        wr_addr         = row_reg;
        wr_lane         = '0;
        wr_data         = '0;

        if (pend_reg && (state_reg == ST_SWEEP || state_reg == ST_SWEEP_END)) begin
            wr_en        = 1'b1;
            wr_addr      = sweep_addr_reg;
            wr_lane      = freed;
            removed_next = removed_reg + CNT_W'($countones(freed));
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_lane  = '1;
                row_next = row_reg + BW'(1);
                if (row_reg == BW'(BUCKETS - 1)) begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    act_next     = s_tuser;
                    fam_next     = s_tdata[0];
                    ctx_next     = s_tdata[16:1];
                    prefix_next  = s_tdata[0] ? s_tdata[80:17]
                                              : {s_tdata[80:49], 32'd0};
                    now_next     = now64[TIME_BITS-1:0];
                    removed_next = '0;
                    row_next     = '0;
                    pend_next    = 1'b0;
                    verdict_next = VERDICT_MAINT;
                    priority if (s_tuser == ACT_CHECK) begin
                        hash_start_next = 1'b1;
                        state_next      = ST_HASH;
                    end else if (s_tuser == ACT_SWEEP || s_tuser == ACT_FLUSH) begin
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    rd_en       = 1'b1;
                    rd_addr     = hash_bucket;
                    bucket_next = hash_bucket;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                hit_next      = found_hit;
                hit_way_next  = found_hit_way;
                free_next     = found_free;
                free_way_next = found_free_way;
                last_next     = found_last;
                tok_next      = found_tok;
                state_next    = ST_ELAPSE;
            end
            ST_ELAPSE: begin
                diff_next  = (now_reg >= last_reg) ? now_reg - last_reg : '0;
                state_next = ST_REFILL;
            end
            ST_REFILL: begin
                t_next     = (diff_reg >= TIME_BITS'(ceil_reg)) ? {1'b0, ceil_reg}
                             : {1'b0, tok_reg} + {1'b0, diff_reg[31:0]};
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                wr_addr = bucket_reg;
                wr_data[0] = 1'b1;
                wr_data[C_LSB-1:P_LSB] = prefix_reg;
                wr_data[T_LSB-1:C_LSB] = tagctx;
                wr_data[K_LSB-1:T_LSB] = now_reg;
                if (hit_reg) begin
                    wr_en = 1'b1;
                    wr_lane[hit_way_reg] = 1'b1;
                    if (cap >= cost_reg) begin
                        wr_data[ENTRY_W-1:K_LSB] = cap - cost_reg;
                        verdict_next = VERDICT_ALLOW;
                    end else begin
                        wr_data[ENTRY_W-1:K_LSB] = cap;
                        verdict_next = VERDICT_NO_TOKENS;
                    end
                end else if (live_reg >= CNT_W'(limit_reg) || !free_reg) begin
                    verdict_next = VERDICT_FULL;
                end else begin
                    wr_en = 1'b1;
                    wr_lane[free_way_reg] = 1'b1;
                    wr_data[ENTRY_W-1:K_LSB] = new_tok;
                    live_next    = live_reg + CNT_W'(1);
                    verdict_next = VERDICT_ALLOW;
                end
                state_next = ST_RESULT;
            end
            ST_SWEEP: begin
                rd_en           = 1'b1;
                rd_addr         = row_reg;
                sweep_addr_next = row_reg;
                pend_next       = 1'b1;
                row_next        = row_reg + BW'(1);
                if (row_reg == BW'(BUCKETS - 1)) begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END: begin
                pend_next  = 1'b0;
                state_next = ST_SWEEP_FIN;
            end
            ST_SWEEP_FIN: begin
                live_next  = (live_reg > removed_reg) ? live_reg - removed_reg : '0;
                row_next   = '0;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, live_reg[FIELD_CNT_W-1:0],
                                     removed_reg[FIELD_CNT_W-1:0], verdict_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            row_reg        <= '0;
            pend_reg       <= 1'b0;
            hash_start_reg <= 1'b0;
            live_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            pend_reg       <= pend_next;
            hash_start_reg <= hash_start_next;
            live_reg       <= live_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        fam_reg        <= fam_next;
        ctx_reg        <= ctx_next;
        prefix_reg     <= prefix_next;
        now_reg        <= now_next;
        bucket_reg     <= bucket_next;
        sweep_addr_reg <= sweep_addr_next;
        hit_reg        <= hit_next;
        hit_way_reg    <= hit_way_next;
        free_reg       <= free_next;
        free_way_reg   <= free_way_next;
        last_reg       <= last_next;
        tok_reg        <= tok_next;
        diff_reg       <= diff_next;
        t_reg          <= t_next;
        removed_reg    <= removed_next;
        verdict_reg    <= verdict_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_live_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CNT_W'(SLOTS))
        else $error("live entry count beyond table size");

    a_rw_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same row");

    a_update_one_way: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && wr_en) |-> $onehot(wr_lane))
        else $error("request update touches more than one way");

    a_check_starts_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == ACT_CHECK) |=> (hash_start_reg && state_reg == ST_HASH))
        else $error("check request did not start the hash");

endmodule

@@ hw/rtl/psl_hash.sv @@
// Keyed SipHash-1-3 unit, half a round per cycle, with bucket reduction.
module psl_hash #(
    parameter int BUCKETS = 8192
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psl_pkg::hash_ctl_t            ctl,
    input  logic [63:0]                   key_lo,
    input  logic [63:0]                   key_hi,
    input  logic [63:0]                   word0,
    input  logic [63:0]                   word1,
    input  logic [63:0]                   word2,
    output logic                          done,
    output logic [$clog2(BUCKETS)-1:0]    bucket
);
    import psl_pkg::*;

    localparam int  BW      = $clog2(BUCKETS);
    localparam bit  IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [3:0][63:0] half_a(input logic [3:0][63:0] v);
        logic [3:0][63:0] o;
        o    = v;
        o[0] = v[0] + v[1];
        o[1] = rotl(v[1], 13) ^ o[0];
        o[0] = rotl(o[0], 32);
        o[2] = v[2] + v[3];
        o[3] = rotl(v[3], 16) ^ o[2];
        half_a = o;
    endfunction

    function automatic logic [3:0][63:0] half_b(input logic [3:0][63:0] v);
        logic [3:0][63:0] o;
        o    = v;
        o[0] = v[0] + v[3];
        o[3] = rotl(v[3], 21) ^ o[0];
        o[2] = v[2] + v[1];
        o[1] = rotl(v[1], 17) ^ o[2];
        o[2] = rotl(o[2], 32);
        half_b = o;
    endfunction

    hash_state_t      state_reg, state_next;
    logic [3:0][63:0] v_reg, v_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             ipv6_reg, ipv6_next;
    logic [63:0]      h_reg, h_next;
    logic [BW:0]      rem_reg, rem_next;
    logic [6:0]       bit_reg, bit_next;
    logic             done_reg, done_next;
    logic [BW-1:0]    bucket_reg, bucket_next;

    logic [2:0]       rnd;
    logic [2:0]       nwords;
    logic [63:0]      w;
    logic [3:0][63:0] a;
    logic [3:0][63:0] b;
    logic [3:0]       last_half;
    logic [63:0]      fold;
    logic [BW:0]      shifted;

    assign rnd       = cnt_reg[3:1];
    assign nwords    = ipv6_reg ? 3'd3 : 3'd2;
    assign last_half = ipv6_reg ? 4'd11 : 4'd9;
    assign fold      = v_reg[0] ^ v_reg[1] ^ v_reg[2] ^ v_reg[3];
    assign shifted   = {rem_reg[BW-1:0], h_reg[63]};

    always_comb begin
        priority case (rnd)
            3'd0:    w = word0;
            3'd1:    w = word1;
            default: w = word2;
        endcase
        a = v_reg;
        if (!cnt_reg[0]) begin
            if (rnd < nwords) a[3] = a[3] ^ w;
            if (rnd == nwords) a[2] = a[2] ^ 64'hff;
            b = half_a(a);
        end else begin
            b = half_b(a);
            if (rnd < nwords) b[0] = b[0] ^ w;
        end
    end

    always_comb begin
        state_next  = state_reg;
        v_next      = v_reg;
        cnt_next    = cnt_reg;
        ipv6_next   = ipv6_reg;
        h_next      = h_reg;
        rem_next    = rem_reg;
        bit_next    = bit_reg;
        done_next   = 1'b0;
        bucket_next = bucket_reg;
        unique case (state_reg)
            HS_IDLE: begin
                if (ctl.start) begin
                    v_next[0]  = key_lo ^ SIP_C0;
                    v_next[1]  = key_hi ^ SIP_C1;
                    v_next[2]  = key_lo ^ SIP_C2;
                    v_next[3]  = key_hi ^ SIP_C3;
                    cnt_next   = 4'd0;
                    ipv6_next  = ctl.ipv6;
                    state_next = HS_ROUND;
                end
            end
            HS_ROUND: begin
                v_next   = b;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == last_half) state_next = HS_FOLD;
            end
            HS_FOLD: begin
                if (IS_POW2) begin
                    bucket_next = fold[BW-1:0];
                    done_next   = 1'b1;
                    state_next  = HS_IDLE;
                end else begin
                    h_next     = fold;
                    rem_next   = '0;
                    bit_next   = 7'd0;
                    state_next = HS_MOD;
                end
            end
            HS_MOD: begin
                rem_next = (shifted >= (BW + 1)'(BUCKETS))
                           ? shifted - (BW + 1)'(BUCKETS) : shifted;
                h_next   = h_reg << 1;
                bit_next = bit_reg + 7'd1;
                if (bit_reg == 7'd63) begin
                    bucket_next = rem_next[BW-1:0];
                    done_next   = 1'b1;
                    state_next  = HS_IDLE;
                end
            end
            default: state_next = HS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        cnt_reg    <= cnt_next;
        ipv6_reg   <= ipv6_next;
        h_reg      <= h_next;
        rem_reg    <= rem_next;
        bit_reg    <= bit_next;
        bucket_reg <= bucket_next;
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

@@ hw/rtl/psl_ram.sv @@
// Bucket table memory: one row per bucket, one lane per way, lane write enables.
module psl_ram #(
    parameter int DEPTH  = 8192,
    parameter int LANES  = 8,
    parameter int LANE_W = 162
) (
    input  logic                               aclk,
    input  logic                               rd_en,
    input  logic [$clog2(DEPTH)-1:0]           rd_addr,
    output logic [LANES-1:0][LANE_W-1:0]       rd_data,
    input  logic                               wr_en,
    input  logic [$clog2(DEPTH)-1:0]           wr_addr,
    input  logic [LANES-1:0]                   wr_lane,
    input  logic [LANE_W-1:0]                  wr_data
);
    logic [LANES-1:0][LANE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            if (wr_en && wr_lane[l]) begin
                mem[wr_addr][l] <= wr_data;
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the per-source token bucket limiter with a built-in scoreboard.
module tb;
    import psl_pkg::*;

    localparam int NBUCKETS = 8192;
    localparam int NWAYS    = 8;
    localparam int WATCHDOG = 60000;

    typedef struct {
        logic [63:0] prefix;
        logic [16:0] ctx;
        logic [47:0] last;
        logic [31:0] tokens;
    } slot_t;

    typedef struct {
        logic [1:0]  verdict;
        logic [16:0] removed;
        logic [16:0] live;
    } outcome_t;

    class limiter_scoreboard;
        logic [31:0] cost, ceiling, timeout;
        logic [16:0] limit;
        logic [63:0] key_lo, key_hi;
        slot_t       table_q[int];
        logic [16:0] live;
        outcome_t    pending_q[$];
        int          errors;

        function void reset_state();
            cost = 50000; ceiling = 250000; timeout = 1000000; limit = 65536;
            key_lo = 0; key_hi = 0; live = 0; errors = 0;
            table_q.delete();
            pending_q.delete();
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                REG_COST:     cost = data[31:0];
                REG_CEILING:  ceiling = data[31:0];
                REG_TIMEOUT:  timeout = data[31:0];
                REG_LIMIT:    limit = data[16:0];
                REG_KEY_LOW:  key_lo = data;
                REG_KEY_HIGH: key_hi = data;
                default: ;
            endcase
        endfunction

        function logic [63:0] rotl(logic [63:0] x, int r);
            return (x << r) | (x >> (64 - r));
        endfunction

        function void sip_round(ref logic [63:0] v[4]);
            v[0] += v[1]; v[1] = rotl(v[1], 13); v[1] ^= v[0]; v[0] = rotl(v[0], 32);
            v[2] += v[3]; v[3] = rotl(v[3], 16); v[3] ^= v[2];
            v[0] += v[3]; v[3] = rotl(v[3], 21); v[3] ^= v[0];
            v[2] += v[1]; v[1] = rotl(v[1], 17); v[1] ^= v[2]; v[2] = rotl(v[2], 32);
        endfunction

        function int bucket_of(logic fam, logic [15:0] ctx, logic [63:0] pfx);
            logic [63:0] v[4];
            logic [63:0] w[3];
            logic [63:0] sw;
            logic [63:0] h;
            int n;
            sw = {<<8{pfx}};
            w[0] = {48'd0, ctx};
            if (!fam) begin
                w[1] = {8'd12, 24'd0, sw[31:0]};
                n = 2;
            end else begin
                w[1] = sw;
                w[2] = {8'd16, 56'd0};
                n = 3;
            end
            v[0] = key_lo ^ SIP_C0; v[1] = key_hi ^ SIP_C1;
            v[2] = key_lo ^ SIP_C2; v[3] = key_hi ^ SIP_C3;
            for (int i = 0; i < n; i++) begin
                v[3] ^= w[i];
                sip_round(v);
                v[0] ^= w[i];
            end
            v[2] ^= 64'hff;
            sip_round(v); sip_round(v); sip_round(v);
            h = v[0] ^ v[1] ^ v[2] ^ v[3];
            return int'(h % NBUCKETS);
        endfunction

        function void note_request(logic [1:0] act, logic fam, logic [15:0] ctx,
                                   logic [63:0] pfx, logic [47:0] now);
            outcome_t o;
            int base, hit, free_slot;
            logic [16:0] tag;
            logic [63:0] diff, t;
            int gone[$];
            o.verdict = VERDICT_MAINT;
            o.removed = 0;
            if (act == ACT_CHECK) begin
                if (!fam) pfx[31:0] = 0;
                tag = {fam, ctx};
                base = bucket_of(fam, ctx, pfx) * NWAYS;
                hit = -1;
                free_slot = -1;
                for (int i = 0; i < NWAYS; i++) begin
                    if (table_q.exists(base + i)) begin
                        if (hit < 0 && table_q[base+i].prefix == pfx &&
                            table_q[base+i].ctx == tag) hit = base + i;
                    end else if (free_slot < 0) begin
                        free_slot = base + i;
                    end
                end
                if (hit >= 0) begin
                    diff = (now >= table_q[hit].last) ? 64'(now - table_q[hit].last) : 0;
                    if (diff >= 64'(ceiling)) t = 64'(ceiling);
                    else t = 64'(table_q[hit].tokens) + diff;
                    if (t > 64'(ceiling)) t = 64'(ceiling);
                    table_q[hit].last = now;
                    if (t >= 64'(cost)) begin
                        table_q[hit].tokens = 32'(t - 64'(cost));
                        o.verdict = VERDICT_ALLOW;
                    end else begin
                        table_q[hit].tokens = t[31:0];
                        o.verdict = VERDICT_NO_TOKENS;
                    end
                end else if (live >= limit || free_slot < 0) begin
                    o.verdict = VERDICT_FULL;
                end else begin
                    table_q[free_slot] = '{pfx, tag, now,
                                           (ceiling >= cost) ? ceiling - cost : 32'd0};
                    live++;
                    o.verdict = VERDICT_ALLOW;
                end
            end else if (act == ACT_SWEEP || act == ACT_FLUSH) begin
                foreach (table_q[s])
                    if (act == ACT_FLUSH || (table_q[s].last <= now &&
                        64'(now - table_q[s].last) > 64'(timeout))) gone.push_back(s);
                foreach (gone[k]) begin
                    table_q.delete(gone[k]);
                    o.removed++;
                    if (live > 0) live--;
                end
            end
            o.live = live;
            pending_q.push_back(o);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            outcome_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, d);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (d[1:0] !== e.verdict) begin
                $display("%0t: verdict expected %0d actual %0d", $time, e.verdict, d[1:0]);
                errors++;
            end
            if (d[18:2] !== e.removed) begin
                $display("%0t: removed_count expected %0d actual %0d",
                         $time, e.removed, d[18:2]);
                errors++;
            end
            if (d[35:19] !== e.live) begin
                $display("%0t: live_count expected %0d actual %0d", $time, e.live, d[35:19]);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    limiter_scoreboard sb;
    logic [47:0] now_ticks;
    logic        rx_hold;
    bit          hold_go;
    int          stall_pct;
    int          rx_phase;
    int          quiet_cycles;
    logic [15:0] pool_ctx[24];
    logic [63:0] pool_pfx[24];
    logic        pool_fam[24];

    per_source_token_bucket_limiter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial aclk = 0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata[0], s_tdata[16:1], s_tdata[80:17],
                            s_tdata[128:81]);
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL per_source_token_bucket_limiter");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (rx_phase == 0) begin
            case ($urandom_range(0, 2))
                0: stall_pct <= 0;
                1: stall_pct <= 30;
                default: stall_pct <= 75;
            endcase
        end
        rx_phase <= (rx_phase + 1) % 128;
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        rx_hold = 0;
        wait (hold_go);
        @(posedge aclk);
        rx_hold = 1;
        repeat (400) @(posedge aclk);
        rx_hold = 0;
    end

    task automatic send_request(logic [1:0] act, logic fam, logic [15:0] ctx,
                                logic [63:0] pfx, logic [47:0] now);
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, now, pfx, ctx, fam};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic advance_time(int step);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) now_ticks = {$urandom, $urandom} & 48'hffff_ffff_ffff;
        else if (r < 5) now_ticks = now_ticks - 48'($urandom_range(0, step));
        else now_ticks = now_ticks + 48'($urandom_range(0, step));
    endtask

    task automatic random_phase(int items, int step);
        int burst, r, p;
        logic [1:0] act;
        for (int i = 0; i < 24; i++) begin
            pool_ctx[i] = $urandom;
            pool_pfx[i] = {$urandom, $urandom};
            pool_fam[i] = $urandom;
        end
        burst = $urandom_range(1, 20);
        for (int n = 0; n < items; n++) begin
            advance_time(step);
            r = $urandom_range(0, 99);
            p = $urandom_range(0, 23);
            act = (r < 92) ? ACT_CHECK : (r < 95) ? ACT_SWEEP : (r < 97) ? ACT_FLUSH : 2'd3;
            if (r < 86)
                send_request(act, pool_fam[p], pool_ctx[p], pool_pfx[p], now_ticks);
            else
                send_request(act, $urandom, $urandom, {$urandom, $urandom}, now_ticks);
            if (n == items / 2) hold_go = 1;
            burst--;
            if (burst == 0) begin
                s_tvalid <= 0;
                repeat ($urandom_range(0, 8)) @(posedge aclk);
                burst = $urandom_range(1, 20);
            end
        end
        drain();
    endtask

    initial begin
        logic [63:0] pfx;
        logic [63:0] same_pfx[$];
        int target;
        sb = new();
        sb.reset_state();
        aresetn = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0; m_tready = 0;
        hold_go = 0; stall_pct = 0; rx_phase = 0; quiet_cycles = 0; now_ticks = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_request(ACT_CHECK, 0, 16'h0000, 64'h0, 48'h0);
        send_request(ACT_CHECK, 1, 16'hffff, 64'hffff_ffff_ffff_ffff, 48'hffff_ffff_ffff);
        send_request(ACT_CHECK, 0, 16'h1234, 64'hc0a8_0001_dead_beef, 48'd10);
        repeat (5) send_request(ACT_CHECK, 0, 16'h1234, 64'hc0a8_0001_0000_0000, 48'd10);
        send_request(ACT_CHECK, 0, 16'h1234, 64'hc0a8_0001_0000_0000, 48'd5);
        send_request(ACT_CHECK, 1, 16'h1234, 64'hc0a8_0001_0000_0000, 48'd20);
        send_request(2'd3, 1, 16'hffff, 64'hffff_ffff_ffff_ffff, 48'd30);
        send_request(ACT_SWEEP, 0, 0, 0, 48'd1000000);
        send_request(ACT_SWEEP, 1, 16'hffff, 64'h1, 48'd1000100);
        send_request(ACT_FLUSH, 0, 0, 0, 48'd1000200);

        target = sb.bucket_of(1, 16'h0007, 64'h0123_4567_89ab_cdef);
        same_pfx.push_back(64'h0123_4567_89ab_cdef);
        for (int k = 0; k < 400000 && same_pfx.size() < 9; k++) begin
            pfx = {$urandom, $urandom};
            if (sb.bucket_of(1, 16'h0007, pfx) == target) same_pfx.push_back(pfx);
        end
        foreach (same_pfx[k]) send_request(ACT_CHECK, 1, 16'h0007, same_pfx[k], 48'd2000000);
        send_request(ACT_FLUSH, 0, 0, 0, 48'd2000001);
        now_ticks = 48'd2000001;
        drain();

        write_reg(REG_KEY_LOW, {$urandom, $urandom});
        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
        random_phase(220, 60000);

        write_reg(REG_COST, 1);
        write_reg(REG_CEILING, 32'hffff_ffff);
        write_reg(REG_TIMEOUT, 1);
        write_reg(REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
        random_phase(200, 4);

        write_reg(REG_COST, 32'hffff_ffff);
        write_reg(REG_CEILING, 1);
        write_reg(REG_TIMEOUT, 32'hffff_ffff);
        write_reg(REG_LIMIT, 0);
        write_reg(REG_KEY_LOW, 0);
        write_reg(REG_KEY_HIGH, 0);
        random_phase(150, 3);

        write_reg(REG_COST, $urandom_range(1, 200));
        write_reg(REG_CEILING, $urandom_range(1, 1000));
        write_reg(REG_TIMEOUT, $urandom_range(1, 3000));
        write_reg(REG_LIMIT, $urandom_range(1, 20));
        random_phase(230, 300);

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("PASS per_source_token_bucket_limiter");
        end else begin
            $display("FAIL per_source_token_bucket_limiter");
        end
        $finish;
    end
endmodule
